>>> rtl/isss_pkg.sv
// Shared types, field layout and codes for the incremental split square sums block.
package isss_pkg;

    // Fixed field widths.
    localparam int ACTION_W   = 2;
    localparam int CAT_W      = 6;
    localparam int TOTAL_W    = 16;
    localparam int SQ_W       = 32;
    localparam int SUM_W      = SQ_W + 1;
    localparam int STATUS_W   = 2;

    // Stream packing.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 104;

    localparam int IN_ACT_LO  = 0;
    localparam int IN_CAT_LO  = IN_ACT_LO + ACTION_W;

    localparam int OUT_LT_LO  = 0;
    localparam int OUT_LSQ_LO = OUT_LT_LO + TOTAL_W;
    localparam int OUT_RT_LO  = OUT_LSQ_LO + SQ_W;
    localparam int OUT_RSQ_LO = OUT_RT_LO + TOTAL_W;
    localparam int OUT_ST_LO  = OUT_RSQ_LO + SQ_W;
    localparam int OUT_USED_W = OUT_ST_LO + STATUS_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_MOVE  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_MISSING  = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // Control to the count store: read enable from the input accept, write and clear from the update stage.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_store_ctl;

endpackage

>>> rtl/isss_count_store.sv
// Per-category left/right count memories with valid bits and write forwarding.
module isss_count_store #(
    parameter int CATEGORIES = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  isss_pkg::t_store_ctl          i_ctl,
    input  logic [$clog2(CATEGORIES)-1:0] i_rd_idx,
    input  logic [$clog2(CATEGORIES)-1:0] i_cur_idx,
    input  logic [$clog2(CATEGORIES)-1:0] i_wr_idx,
    input  logic [COUNT_BITS-1:0]         i_wr_left,
    input  logic [COUNT_BITS-1:0]         i_wr_right,
    output logic [COUNT_BITS-1:0]         o_left,
    output logic [COUNT_BITS-1:0]         o_right
);

    localparam int IDX_W = $clog2(CATEGORIES);

    logic [COUNT_BITS-1:0] r_mem_left  [CATEGORIES];
    logic [COUNT_BITS-1:0] r_mem_right [CATEGORIES];
    logic [COUNT_BITS-1:0] r_rd_left;
    logic [COUNT_BITS-1:0] r_rd_right;
    logic [CATEGORIES-1:0] r_vld;

    logic                  r_fwd_vld;
    logic [IDX_W-1:0]      r_fwd_idx;
    logic [COUNT_BITS-1:0] r_fwd_left;
    logic [COUNT_BITS-1:0] r_fwd_right;

    logic                  w_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem_left[i_wr_idx]  <= i_wr_left;
            r_mem_right[i_wr_idx] <= i_wr_right;
        end
        if (i_ctl.rd_en) begin
            r_rd_left  <= r_mem_left[i_rd_idx];
            r_rd_right <= r_mem_right[i_rd_idx];
        end
    end

    // Entry valid flags; clear drops them all at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_vld     <= '0;
            r_fwd_vld <= 1'b0;
        end else if (i_ctl.wr_en) begin
            r_vld[i_wr_idx] <= 1'b1;
            r_fwd_vld       <= 1'b1;
        end
    end

    // Last write, covers a read that raced it on the same edge.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_fwd_idx   <= i_wr_idx;
            r_fwd_left  <= i_wr_left;
            r_fwd_right <= i_wr_right;
        end
    end

    assign w_hit = r_fwd_vld && (r_fwd_idx == i_cur_idx);

    always_comb begin
        if (w_hit) begin
            o_left  = r_fwd_left;
            o_right = r_fwd_right;
        end else if (r_vld[i_cur_idx]) begin
            o_left  = r_rd_left;
            o_right = r_rd_right;
        end else begin
            o_left  = '0;
            o_right = '0;
        end
    end

endmodule

>>> rtl/incremental_split_square_sums.sv
// Top level: incremental left/right category counts and square sums for a split candidate.
//
//  channel  | dir | handshake                     | payload (low bit up)
//  ---------+-----+-------------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: action, category; tuser: is_missing
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: left_total, left_square_sum,
//           |     |                               |        right_total, right_square_sum, status
//
//  One beat per cycle sustained while the output is not stalled.
//  A beat passes the registered read of the count memories, then one update
//  stage (one 33-bit add/compare per side) and then the output register.
//  Back-to-back beats on one category are covered by forwarding the last write.
//  Reset (i_rst_n low, synchronous) empties the pipe and marks every count zero
//  through per-entry valid bits; no clearing pass is needed.
//  A stalled output holds the update stage; input is taken while that stage can drain.
module incremental_split_square_sums #(
    parameter int CATEGORIES = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] action, [7:2] category
    input  logic [isss_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] is_missing
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] left_total, [47:16] left_square_sum, [63:48] right_total,
    // [95:64] right_square_sum, [97:96] status, [103:98] zero
    output logic [isss_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int IDX_W   = $clog2(CATEGORIES);
    localparam int EXT_W   = (IDX_W > isss_pkg::CAT_W) ? IDX_W : isss_pkg::CAT_W;

    // ---------------- input decode ----------------
    logic                          w_in_acc;
    logic [isss_pkg::ACTION_W-1:0] w_in_action;
    logic [isss_pkg::CAT_W-1:0]    w_in_cat;
    logic [EXT_W-1:0]              w_in_cat_ext;
    logic [IDX_W-1:0]              w_in_idx;
    logic                          w_in_range;

    assign w_in_acc     = s_axis_tvalid && s_axis_tready;
    assign w_in_action  = s_axis_tdata[isss_pkg::IN_ACT_LO +: isss_pkg::ACTION_W];
    assign w_in_cat     = s_axis_tdata[isss_pkg::IN_CAT_LO +: isss_pkg::CAT_W];
    assign w_in_cat_ext = EXT_W'(w_in_cat);
    assign w_in_idx     = w_in_cat_ext[IDX_W-1:0];
    assign w_in_range   = 32'(w_in_cat) < CATEGORIES;

    // ---------------- update stage registers ----------------
    logic                          r_s1_vld;
    logic [isss_pkg::ACTION_W-1:0] r_s1_action;
    logic [IDX_W-1:0]              r_s1_idx;
    logic                          r_s1_range;
    logic                          r_s1_missing;

    // Side totals and square sums.
    logic [COUNT_BITS-1:0]         r_lt_total;
    logic [COUNT_BITS-1:0]         r_rt_total;
    logic [isss_pkg::SQ_W-1:0]     r_lsq;
    logic [isss_pkg::SQ_W-1:0]     r_rsq;

    // Output register.
    logic                          r_out_vld;
    logic [isss_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                          w_adv;
    assign w_adv         = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || w_adv;

    // ---------------- count store ----------------
    isss_pkg::t_store_ctl          w_ctl;
    logic [COUNT_BITS-1:0]         w_f_l;
    logic [COUNT_BITS-1:0]         w_f_r;
    logic [COUNT_BITS-1:0]         n_wr_left;
    logic [COUNT_BITS-1:0]         n_wr_right;
    logic                          n_wr;
    logic                          n_clr;

    assign w_ctl.rd_en = w_in_acc;
    assign w_ctl.wr_en = w_adv && n_wr;
    assign w_ctl.clr   = w_adv && n_clr;

    isss_count_store #(
        .CATEGORIES (CATEGORIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_rd_idx   (w_in_idx),
        .i_cur_idx  (r_s1_idx),
        .i_wr_idx   (r_s1_idx),
        .i_wr_left  (n_wr_left),
        .i_wr_right (n_wr_right),
        .o_left     (w_f_l),
        .o_right    (w_f_r)
    );

    // ---------------- update logic ----------------
    // 2f+1 for an increment, 2f-1 for a decrement, sums one bit wider to see overflow.
    logic [isss_pkg::SUM_W-1:0]    w_l_add;
    logic [isss_pkg::SUM_W-1:0]    w_r_add;
    logic [COUNT_BITS-1:0]         w_f_r_dec;
    logic [isss_pkg::SQ_W-1:0]     w_r_sub;
    logic [isss_pkg::SQ_W-1:0]     w_r_sub_sq;

    assign w_l_add    = isss_pkg::SUM_W'(r_lsq) + isss_pkg::SUM_W'({w_f_l, 1'b1});
    assign w_r_add    = isss_pkg::SUM_W'(r_rsq) + isss_pkg::SUM_W'({w_f_r, 1'b1});
    assign w_f_r_dec  = w_f_r - 1'b1;
    assign w_r_sub    = isss_pkg::SQ_W'({w_f_r_dec, 1'b1});
    assign w_r_sub_sq = (r_rsq >= w_r_sub) ? (r_rsq - w_r_sub) : '0;

    isss_pkg::t_status             n_status;
    logic [COUNT_BITS-1:0]         n_lt_total;
    logic [COUNT_BITS-1:0]         n_rt_total;
    logic [isss_pkg::SQ_W-1:0]     n_lsq;
    logic [isss_pkg::SQ_W-1:0]     n_rsq;

    always_comb begin
        n_status   = isss_pkg::ST_DONE;
        n_wr       = 1'b0;
        n_clr      = 1'b0;
        n_wr_left  = w_f_l;
        n_wr_right = w_f_r;
        n_lt_total = r_lt_total;
        n_rt_total = r_rt_total;
        n_lsq      = r_lsq;
        n_rsq      = r_rsq;
        case (isss_pkg::t_action'(r_s1_action))
            isss_pkg::ACT_CLEAR: begin
                n_clr      = 1'b1;
                n_lt_total = '0;
                n_rt_total = '0;
                n_lsq      = '0;
                n_rsq      = '0;
            end
            isss_pkg::ACT_ADD: begin
                if (r_s1_missing) begin
                    n_status = isss_pkg::ST_MISSING;
                end else if (!r_s1_range) begin
                    n_status = isss_pkg::ST_ABSENT;
                end else if ((&r_rt_total) || (&w_f_r) || w_r_add[isss_pkg::SQ_W]) begin
                    n_status = isss_pkg::ST_OVERFLOW;
                end else begin
                    n_wr       = 1'b1;
                    n_wr_right = w_f_r + 1'b1;
                    n_rt_total = r_rt_total + 1'b1;
                    n_rsq      = w_r_add[isss_pkg::SQ_W-1:0];
                end
            end
            isss_pkg::ACT_MOVE: begin
                if (r_s1_missing) begin
                    n_status = isss_pkg::ST_MISSING;
                end else if (!r_s1_range || (w_f_r == '0) || (r_rt_total == '0)) begin
                    n_status = isss_pkg::ST_ABSENT;
                end else if ((&r_lt_total) || (&w_f_l) || w_l_add[isss_pkg::SQ_W]) begin
                    n_status = isss_pkg::ST_OVERFLOW;
                end else begin
                    n_wr       = 1'b1;
                    n_wr_left  = w_f_l + 1'b1;
                    n_wr_right = w_f_r_dec;
                    n_lt_total = r_lt_total + 1'b1;
                    n_rt_total = r_rt_total - 1'b1;
                    n_lsq      = w_l_add[isss_pkg::SQ_W-1:0];
                    n_rsq      = w_r_sub_sq;
                end
            end
            default: begin
                // unused action code: no change, reported as done
                n_status = isss_pkg::ST_DONE;
            end
        endcase
    end

    logic [isss_pkg::OUT_DATA_W-1:0] n_out_data;
    always_comb begin
        n_out_data = '0;
        n_out_data[isss_pkg::OUT_LT_LO  +: isss_pkg::TOTAL_W]  = isss_pkg::TOTAL_W'(n_lt_total);
        n_out_data[isss_pkg::OUT_LSQ_LO +: isss_pkg::SQ_W]     = n_lsq;
        n_out_data[isss_pkg::OUT_RT_LO  +: isss_pkg::TOTAL_W]  = isss_pkg::TOTAL_W'(n_rt_total);
        n_out_data[isss_pkg::OUT_RSQ_LO +: isss_pkg::SQ_W]     = n_rsq;
        n_out_data[isss_pkg::OUT_ST_LO  +: isss_pkg::STATUS_W] = n_status;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_lt_total <= '0;
            r_rt_total <= '0;
            r_lsq      <= '0;
            r_rsq      <= '0;
        end else begin
            if (s_axis_tready) begin
                r_s1_vld <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_vld  <= 1'b1;
                r_lt_total <= n_lt_total;
                r_rt_total <= n_rt_total;
                r_lsq      <= n_lsq;
                r_rsq      <= n_rsq;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_action  <= w_in_action;
            r_s1_idx     <= w_in_idx;
            r_s1_range   <= w_in_range;
            r_s1_missing <= s_axis_tuser;
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> rtl/isss_checker.sv
// Port-level checker for incremental_split_square_sums, with its bind.
module isss_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [isss_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic                            w_out_beat;
    logic [isss_pkg::STATUS_W-1:0]   w_status;
    logic [isss_pkg::OUT_ST_LO-1:0]  w_sums;
    logic [isss_pkg::TOTAL_W-1:0]    w_lt;
    logic [isss_pkg::OUT_ST_LO-1:0]  r_prev_sums;
    logic [isss_pkg::TOTAL_W-1:0]    w_prev_lt;

    assign w_out_beat = m_axis_tvalid && m_axis_tready;
    assign w_status   = m_axis_tdata[isss_pkg::OUT_ST_LO +: isss_pkg::STATUS_W];
    assign w_sums     = m_axis_tdata[isss_pkg::OUT_ST_LO-1:0];
    assign w_lt       = m_axis_tdata[isss_pkg::OUT_LT_LO +: isss_pkg::TOTAL_W];
    assign w_prev_lt  = r_prev_sums[isss_pkg::OUT_LT_LO +: isss_pkg::TOTAL_W];

    // Side state as shown by the last result beat; reset state is all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sums <= '0;
        end else if (w_out_beat) begin
            r_prev_sums <= w_sums;
        end
    end

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat && (w_status != isss_pkg::ST_DONE) |-> w_sums == r_prev_sums)
        else $error("rejected update changed the side state");

    a_left_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat |-> (w_lt == w_prev_lt) || (w_lt == w_prev_lt + 1'b1) || (w_lt == '0))
        else $error("left total moved by more than one sample");

    a_no_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[isss_pkg::OUT_DATA_W-1:isss_pkg::OUT_USED_W] == '0)
        else $error("padding bits of result beat not zero");

endmodule

bind incremental_split_square_sums isss_checker u_isss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/incremental_split_square_sums_tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the incremental split square sums block.
module incremental_split_square_sums_tb;

    localparam int N_CAT        = 64;
    localparam int IDLE_PCT     = 29;
    localparam int RANDOM_BEATS = 1650;
    localparam int CALM_FIRST   = 300;
    localparam int CALM_LAST    = 600;
    localparam int SHOW_LIMIT   = 10;
    localparam int DRAIN_LIMIT  = 2000;
    localparam logic [isss_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // One result beat, first field in the low bits.
    typedef struct packed {
        isss_pkg::t_status            status;
        logic [isss_pkg::SQ_W-1:0]    right_sq;
        logic [isss_pkg::TOTAL_W-1:0] right_total;
        logic [isss_pkg::SQ_W-1:0]    left_sq;
        logic [isss_pkg::TOTAL_W-1:0] left_total;
    } t_split_sums;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [isss_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [isss_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // Split state as the block should hold it.
    logic [isss_pkg::TOTAL_W-1:0] left_counts  [N_CAT];
    logic [isss_pkg::TOTAL_W-1:0] right_counts [N_CAT];
    logic [isss_pkg::TOTAL_W-1:0] left_total   = '0;
    logic [isss_pkg::TOTAL_W-1:0] right_total  = '0;
    logic [isss_pkg::SQ_W-1:0]    left_sq      = '0;
    logic [isss_pkg::SQ_W-1:0]    right_sq     = '0;

    t_split_sums sums_expected [$];
    int          fail_count = 0;
    logic        idle_on    = 1'b1;

    incremental_split_square_sums i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int c = 0; c < N_CAT; c++) begin
            left_counts[c]  = '0;
            right_counts[c] = '0;
        end
    end

    task automatic flag(input string msg);
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
            $display("%s", msg);
    endtask

    function automatic void clear_split();
        for (int c = 0; c < N_CAT; c++) begin
            left_counts[c]  = '0;
            right_counts[c] = '0;
        end
        left_total  = '0;
        right_total = '0;
        left_sq     = '0;
        right_sq    = '0;
    endfunction

    // Applies one sample to the split state and returns the beat it should produce.
    function automatic t_split_sums apply_sample(
        input logic [isss_pkg::ACTION_W-1:0] act,
        input logic [isss_pkg::CAT_W-1:0]    cat,
        input logic                          miss);
        t_split_sums                  r;
        isss_pkg::t_status            st;
        logic [isss_pkg::TOTAL_W-1:0] fl;
        logic [isss_pkg::TOTAL_W-1:0] fr;
        logic [isss_pkg::SQ_W:0]      sq;
        logic [isss_pkg::SQ_W:0]      drop;
        st = isss_pkg::ST_DONE;
        if (act == isss_pkg::ACT_CLEAR) begin
            clear_split();
        end else if (act == isss_pkg::ACT_ADD || act == isss_pkg::ACT_MOVE) begin
            if (miss) begin
                st = isss_pkg::ST_MISSING;
            end else if (act == isss_pkg::ACT_ADD) begin
                fr = right_counts[cat];
                sq = (isss_pkg::SQ_W+1)'(right_sq) + (isss_pkg::SQ_W+1)'(fr) * 2 + 1;
                if (right_total == '1 || fr == '1 || sq[isss_pkg::SQ_W]) begin
                    st = isss_pkg::ST_OVERFLOW;
                end else begin
                    right_counts[cat] = fr + 1'b1;
                    right_total       = right_total + 1'b1;
                    right_sq          = sq[isss_pkg::SQ_W-1:0];
                end
            end else begin
                fr = right_counts[cat];
                fl = left_counts[cat];
                sq = (isss_pkg::SQ_W+1)'(left_sq) + (isss_pkg::SQ_W+1)'(fl) * 2 + 1;
                // absent category wins over a full left side
                if (fr == '0 || right_total == '0) begin
                    st = isss_pkg::ST_ABSENT;
                end else if (left_total == '1 || fl == '1 || sq[isss_pkg::SQ_W]) begin
                    st = isss_pkg::ST_OVERFLOW;
                end else begin
                    left_counts[cat]  = fl + 1'b1;
                    left_total        = left_total + 1'b1;
                    left_sq           = sq[isss_pkg::SQ_W-1:0];
                    right_counts[cat] = fr - 1'b1;
                    right_total       = right_total - 1'b1;
                    drop              = (isss_pkg::SQ_W+1)'(fr) * 2 - 1;
                    if ((isss_pkg::SQ_W+1)'(right_sq) >= drop)
                        right_sq = right_sq - drop[isss_pkg::SQ_W-1:0];
                    else
                        right_sq = '0;
                end
            end
        end
        r.status      = st;
        r.right_sq    = right_sq;
        r.right_total = right_total;
        r.left_sq     = left_sq;
        r.left_total  = left_total;
        return r;
    endfunction

    // Sends one beat; called right after a rising edge. tvalid stays high into
    // the next beat when no gap is drawn.
    task automatic send_sample(input logic [isss_pkg::ACTION_W-1:0] act,
                               input logic [isss_pkg::CAT_W-1:0]    cat,
                               input logic                          miss);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cat, act};
        s_axis_tuser  <= miss;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        sums_expected.insert(sums_expected.size(), apply_sample(act, cat, miss));
    endtask

    // Sender holds off until the block has answered every beat.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sums_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver side: random back-pressure.
    always @(posedge i_clk)
        m_axis_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);

    // Result checker: each beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_split_sums got;
        t_split_sums want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_split_sums'(m_axis_tdata[isss_pkg::OUT_USED_W-1:0]);
            if (sums_expected.size() == 0) begin
                flag($sformatf("unexpected result beat %h", m_axis_tdata));
            end else begin
                want = sums_expected.pop_front();
                if (got.left_total !== want.left_total)
                    flag($sformatf("left_total: expected %0d, got %0d",
                                   want.left_total, got.left_total));
                if (got.left_sq !== want.left_sq)
                    flag($sformatf("left_square_sum: expected %0d, got %0d",
                                   want.left_sq, got.left_sq));
                if (got.right_total !== want.right_total)
                    flag($sformatf("right_total: expected %0d, got %0d",
                                   want.right_total, got.right_total));
                if (got.right_sq !== want.right_sq)
                    flag($sformatf("right_square_sum: expected %0d, got %0d",
                                   want.right_sq, got.right_sq));
                if (got.status !== want.status)
                    flag($sformatf("status: expected %0d, got %0d",
                                   want.status, got.status));
                if (m_axis_tdata[isss_pkg::OUT_DATA_W-1:isss_pkg::OUT_USED_W] !== '0)
                    flag($sformatf("pad bits: expected 0, got %h",
                                   m_axis_tdata[isss_pkg::OUT_DATA_W-1:isss_pkg::OUT_USED_W]));
            end
        end
    end

    // Field extremes, every action and the corner cases.
    task automatic test_directed();
        send_sample(isss_pkg::ACT_CLEAR, 6'd0,  1'b1);  // clear ignores the missing flag
        send_sample(isss_pkg::ACT_ADD,   6'd0,  1'b0);
        send_sample(isss_pkg::ACT_ADD,   6'd63, 1'b0);
        send_sample(isss_pkg::ACT_ADD,   6'd63, 1'b0);
        send_sample(isss_pkg::ACT_ADD,   6'd63, 1'b1);  // missing sample
        send_sample(isss_pkg::ACT_MOVE,  6'd63, 1'b1);  // missing sample
        send_sample(isss_pkg::ACT_MOVE,  6'd5,  1'b0);  // nothing on the right
        send_sample(isss_pkg::ACT_MOVE,  6'd63, 1'b0);
        send_sample(isss_pkg::ACT_MOVE,  6'd63, 1'b0);
        send_sample(isss_pkg::ACT_MOVE,  6'd63, 1'b0);  // right count used up
        send_sample(isss_pkg::ACT_MOVE,  6'd0,  1'b0);
        send_sample(isss_pkg::ACT_ADD,   6'd42, 1'b0);
        send_sample(isss_pkg::ACT_ADD,   6'd21, 1'b0);
        send_sample(ACT_UNUSED,          6'd21, 1'b0);  // unused action code
        send_sample(ACT_UNUSED,          6'd42, 1'b1);
        send_sample(isss_pkg::ACT_MOVE,  6'd21, 1'b0);
        send_sample(isss_pkg::ACT_CLEAR, 6'd63, 1'b0);
        send_sample(isss_pkg::ACT_MOVE,  6'd0,  1'b0);  // both sides empty
        send_sample(isss_pkg::ACT_ADD,   6'd1,  1'b0);
        hold_until_drained();
    endtask

    // Mostly adds and moves of held categories, clustered on a few categories
    // so counts grow; the rest is missing samples, unused codes and clears.
    // One stretch runs without idling on either side.
    task automatic test_random();
        int                         pick;
        int                         start;
        logic [isss_pkg::CAT_W-1:0] cat;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS / 2)
                hold_until_drained();
            idle_on <= (n < CALM_FIRST) || (n >= CALM_LAST);
            pick = $urandom_range(99);
            cat  = $urandom_range(1) ? isss_pkg::CAT_W'($urandom_range(7))
                                     : isss_pkg::CAT_W'($urandom_range(N_CAT - 1));
            if (pick < 44) begin
                send_sample(isss_pkg::ACT_ADD, cat, 1'b0);
            end else if (pick < 80) begin
                if ($urandom_range(99) < 85) begin
                    start = $urandom_range(N_CAT - 1);
                    for (int k = 0; k < N_CAT; k++) begin
                        if (right_counts[(start + k) % N_CAT] != '0) begin
                            cat = isss_pkg::CAT_W'((start + k) % N_CAT);
                            break;
                        end
                    end
                end
                send_sample(isss_pkg::ACT_MOVE, cat, 1'b0);
            end else if (pick < 88) begin
                send_sample($urandom_range(1) ? isss_pkg::ACT_ADD : isss_pkg::ACT_MOVE,
                            cat, 1'b1);
            end else if (pick < 93) begin
                send_sample(ACT_UNUSED, cat, 1'($urandom_range(1)));
            end else if (pick < 95) begin
                send_sample(isss_pkg::ACT_CLEAR, cat, 1'($urandom_range(1)));
            end else begin
                send_sample(isss_pkg::ACT_ADD, isss_pkg::CAT_W'($urandom_range(3)), 1'b0);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && sums_expected.size() != 0; n++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sums_expected.size() != 0)
            flag($sformatf("%0d results never arrived", sums_expected.size()));
        if (fail_count == 0)
            $display("incremental_split_square_sums_tb passed");
        else
            $display("incremental_split_square_sums_tb failed");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run.
    initial begin
        #500_000;
        $display("incremental_split_square_sums_tb failed");
        $finish;
    end

endmodule
